// ===== rtl/core/ptsd_pkg.sv =====
// Shared types and constants for the point-triangle distance pipeline
package ptsd_pkg;

    localparam int COORD_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQR_BITS    = 2 * DIFF_BITS;
    localparam int DOT_BITS    = SQR_BITS + 2;
    localparam int HALF_BITS   = DOT_BITS / 2;
    localparam int PROD_BITS   = 2 * DOT_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 4;
    localparam int FRAC_BITS   = 24;
    localparam int WT_BITS     = FRAC_BITS + 1;
    localparam int SCALED_BITS = DIFF_BITS + WT_BITS + 1;
    localparam int SUM_BITS    = SCALED_BITS + 1;
    localparam int DIST_BITS   = 2 * COORD_BITS + 4;
    localparam int REGION_BITS = 3;
    localparam int DIV_LAT     = FRAC_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [DOT_BITS-1:0]   t_dot;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [CROSS_BITS-1:0] t_cross;
    typedef logic [WT_BITS-1:0]           t_weight;

    typedef t_coord [2:0] t_cvec;
    typedef t_diff  [2:0] t_dvec;
    typedef t_dot   [5:0] t_dots;

    localparam t_coord  COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord  COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_weight WT_ONE    = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [REGION_BITS-1:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_C    = 3'd2,
        REG_AB   = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } t_region;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord query_z;
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_a_z;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_b_z;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_coord vertex_c_z;
    } t_in;

    typedef struct packed {
        logic [DIST_BITS-1:0]   sqr_distance;
        t_coord                 nearest_x;
        t_coord                 nearest_y;
        t_coord                 nearest_z;
        logic [REGION_BITS-1:0] region;
    } t_out;

    typedef struct packed {
        t_cvec p;
        t_cvec a;
        t_cvec b;
        t_cvec c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
    } t_geo;

    typedef struct packed {
        t_geo   geo;
        t_dots  d;
        t_cross va;
        t_cross vb;
        t_cross vc;
    } t_geom_res;

    // q = sat(base + floor((e0*w0 + e1*w1) / 2^24))
    typedef struct packed {
        t_cvec   p;
        t_cvec   base;
        t_dvec   e0;
        t_dvec   e1;
        t_region region;
    } t_cls;

endpackage

// ===== rtl/core/ptsd_mul52.sv =====
// Two-stage signed 52x52 multiplier built from four narrow partial products
module ptsd_mul52 (
    input  logic           i_clk,
    input  ptsd_pkg::t_dot i_a,
    input  ptsd_pkg::t_dot i_b,
    output ptsd_pkg::t_prod o_p
);
    import ptsd_pkg::*;

    logic signed [HALF_BITS-1:0]   a_hi, b_hi;
    logic signed [HALF_BITS:0]     a_lo, b_lo;
    logic signed [2*HALF_BITS-1:0] r_hh;
    logic signed [2*HALF_BITS:0]   r_hl, r_lh;
    logic [2*HALF_BITS-1:0]        r_ll;
    t_prod                         r_p;

    assign a_hi = i_a[DOT_BITS-1:HALF_BITS];
    assign b_hi = i_b[DOT_BITS-1:HALF_BITS];
    assign a_lo = {1'b0, i_a[HALF_BITS-1:0]};
    assign b_lo = {1'b0, i_b[HALF_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        r_hh <= a_hi * b_hi;
        r_hl <= a_hi * b_lo;
        r_lh <= a_lo * b_hi;
        r_ll <= i_a[HALF_BITS-1:0] * i_b[HALF_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_p <= (PROD_BITS'(r_hh) <<< (2 * HALF_BITS))
             + ((PROD_BITS'(r_hl) + PROD_BITS'(r_lh)) <<< HALF_BITS)
             + $signed(PROD_BITS'(r_ll));
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/ptsd_div.sv =====
// Pipelined restoring divider for a Q1.24 weight, one quotient bit per stage
module ptsd_div (
    input  logic              i_clk,
    input  ptsd_pkg::t_cross  i_num,
    input  ptsd_pkg::t_cross  i_den,
    output ptsd_pkg::t_weight o_weight
);
    import ptsd_pkg::*;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_DIV
    } t_mode;

    t_mode                  r_mode [FRAC_BITS+1];
    logic [CROSS_BITS-1:0]  r_rem  [FRAC_BITS+1];
    logic [CROSS_BITS-1:0]  r_den  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]   r_quo  [FRAC_BITS+1];
    t_mode                  n_mode;

    always_comb begin
        if (i_den <= 0 || i_num <= 0) begin
            n_mode = MODE_ZERO;
        end else if (i_num >= i_den) begin
            n_mode = MODE_ONE;
        end else begin
            n_mode = MODE_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode[0] <= n_mode;
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
    end

    // remainder stays below the divisor, so the doubled value never overflows
    for (genvar s = 1; s <= FRAC_BITS; s++) begin : g_stage
        logic [CROSS_BITS-1:0] rem2;
        logic                  ge;
        assign rem2 = {r_rem[s-1][CROSS_BITS-2:0], 1'b0};
        assign ge   = rem2 >= r_den[s-1];
        always_ff @(posedge i_clk) begin
            r_mode[s] <= r_mode[s-1];
            r_den[s]  <= r_den[s-1];
            r_rem[s]  <= ge ? rem2 - r_den[s-1] : rem2;
            r_quo[s]  <= {r_quo[s-1][FRAC_BITS-2:0], ge};
        end
    end

    always_comb begin
        unique case (r_mode[FRAC_BITS])
            MODE_ZERO: o_weight = '0;
            MODE_ONE:  o_weight = WT_ONE;
            MODE_DIV:  o_weight = {1'b0, r_quo[FRAC_BITS]};
            default:   o_weight = '0;
        endcase
    end

endmodule

// ===== rtl/core/ptsd_geom.sv =====
// Front end: edge vectors, the six dot products and the three region cross terms
module ptsd_geom (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ptsd_pkg::t_in        i_item,
    output logic                 o_valid,
    output ptsd_pkg::t_geom_res  o_res
);
    import ptsd_pkg::*;

    t_geo  n_geo;
    t_dvec n_ap, n_bp, n_cp;

    logic  r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;
    t_geo  r1_geo, r2_geo, r3_geo, r4_geo, r5_geo;
    t_dvec r1_ap, r1_bp, r1_cp;
    t_dots r3_d, r4_d, r5_d;
    t_geom_res r6_res;

    logic signed [DIFF_BITS-1:0] m_l [6][3];
    logic signed [DIFF_BITS-1:0] m_r [6][3];
    logic signed [SQR_BITS-1:0]  r2_prod [6][3];
    t_prod                       m_prod [6];

    always_comb begin
        n_geo.p = {i_item.query_z, i_item.query_y, i_item.query_x};
        n_geo.a = {i_item.vertex_a_z, i_item.vertex_a_y, i_item.vertex_a_x};
        n_geo.b = {i_item.vertex_b_z, i_item.vertex_b_y, i_item.vertex_b_x};
        n_geo.c = {i_item.vertex_c_z, i_item.vertex_c_y, i_item.vertex_c_x};
        for (int i = 0; i < 3; i++) begin
            n_geo.ab[i] = DIFF_BITS'($signed(n_geo.b[i])) - DIFF_BITS'($signed(n_geo.a[i]));
            n_geo.ac[i] = DIFF_BITS'($signed(n_geo.c[i])) - DIFF_BITS'($signed(n_geo.a[i]));
            n_geo.bc[i] = DIFF_BITS'($signed(n_geo.c[i])) - DIFF_BITS'($signed(n_geo.b[i]));
            n_ap[i]     = DIFF_BITS'($signed(n_geo.p[i])) - DIFF_BITS'($signed(n_geo.a[i]));
            n_bp[i]     = DIFF_BITS'($signed(n_geo.p[i])) - DIFF_BITS'($signed(n_geo.b[i]));
            n_cp[i]     = DIFF_BITS'($signed(n_geo.p[i])) - DIFF_BITS'($signed(n_geo.c[i]));
        end
    end

    // d1..d6 = ab.ap, ac.ap, ab.bp, ac.bp, ab.cp, ac.cp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_l[0][i] = r1_geo.ab[i];  m_r[0][i] = r1_ap[i];
            m_l[1][i] = r1_geo.ac[i];  m_r[1][i] = r1_ap[i];
            m_l[2][i] = r1_geo.ab[i];  m_r[2][i] = r1_bp[i];
            m_l[3][i] = r1_geo.ac[i];  m_r[3][i] = r1_bp[i];
            m_l[4][i] = r1_geo.ab[i];  m_r[4][i] = r1_cp[i];
            m_l[5][i] = r1_geo.ac[i];  m_r[5][i] = r1_cp[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_geo <= n_geo;
        r1_ap  <= n_ap;
        r1_bp  <= n_bp;
        r1_cp  <= n_cp;
        r2_geo <= r1_geo;
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
                r2_prod[k][i] <= m_l[k][i] * m_r[k][i];
            end
        end
        r3_geo <= r2_geo;
        for (int k = 0; k < 6; k++) begin
            r3_d[k] <= DOT_BITS'(r2_prod[k][0]) + DOT_BITS'(r2_prod[k][1])
                     + DOT_BITS'(r2_prod[k][2]);
        end
        r4_geo <= r3_geo;
        r4_d   <= r3_d;
        r5_geo <= r4_geo;
        r5_d   <= r4_d;
        r6_res.geo <= r5_geo;
        r6_res.d   <= r5_d;
        r6_res.vc  <= CROSS_BITS'(m_prod[0]) - CROSS_BITS'(m_prod[1]);
        r6_res.vb  <= CROSS_BITS'(m_prod[2]) - CROSS_BITS'(m_prod[3]);
        r6_res.va  <= CROSS_BITS'(m_prod[4]) - CROSS_BITS'(m_prod[5]);
    end

    // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
    ptsd_mul52 u_mul0 (.i_clk(i_clk), .i_a(r3_d[0]), .i_b(r3_d[3]), .o_p(m_prod[0]));
    ptsd_mul52 u_mul1 (.i_clk(i_clk), .i_a(r3_d[2]), .i_b(r3_d[1]), .o_p(m_prod[1]));
    ptsd_mul52 u_mul2 (.i_clk(i_clk), .i_a(r3_d[4]), .i_b(r3_d[1]), .o_p(m_prod[2]));
    ptsd_mul52 u_mul3 (.i_clk(i_clk), .i_a(r3_d[0]), .i_b(r3_d[5]), .o_p(m_prod[3]));
    ptsd_mul52 u_mul4 (.i_clk(i_clk), .i_a(r3_d[2]), .i_b(r3_d[5]), .o_p(m_prod[4]));
    ptsd_mul52 u_mul5 (.i_clk(i_clk), .i_a(r3_d[4]), .i_b(r3_d[3]), .o_p(m_prod[5]));

    assign o_valid = r6_valid;
    assign o_res   = r6_res;

endmodule

// ===== rtl/core/ptsd_back.sv =====
// Back end: closest point from weights, then the squared distance
module ptsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptsd_pkg::t_cls    i_cls,
    input  ptsd_pkg::t_weight i_w0,
    input  ptsd_pkg::t_weight i_w1,
    output logic              o_valid,
    output ptsd_pkg::t_out    o_result
);
    import ptsd_pkg::*;

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [SCALED_BITS-1:0] r1_p0 [3];
    logic signed [SCALED_BITS-1:0] r1_p1 [3];
    t_cvec   r1_base, r1_pt, r2_pt, r2_q, r3_q;
    t_region r1_region, r2_region, r3_region;
    logic signed [SUM_BITS-1:0] n_sum [3];
    logic signed [SUM_BITS-1:0] n_pos [3];
    t_cvec   n_q;
    logic signed [DIFF_BITS-1:0] n_diff [3];
    logic signed [SQR_BITS-1:0]  r3_sq [3];
    t_out    r4_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // arithmetic shift is the floor of the signed Q27.24 product sum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SUM_BITS'(r1_p0[i]) + SUM_BITS'(r1_p1[i]);
            n_pos[i] = SUM_BITS'($signed(r1_base[i])) + (n_sum[i] >>> FRAC_BITS);
            if (n_pos[i] > SUM_BITS'(COORD_MAX)) begin
                n_q[i] = COORD_MAX;
            end else if (n_pos[i] < SUM_BITS'(COORD_MIN)) begin
                n_q[i] = COORD_MIN;
            end else begin
                n_q[i] = COORD_BITS'(n_pos[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_diff[i] = DIFF_BITS'($signed(r2_pt[i])) - DIFF_BITS'($signed(r2_q[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_p0[i] <= $signed(i_cls.e0[i]) * $signed({1'b0, i_w0});
            r1_p1[i] <= $signed(i_cls.e1[i]) * $signed({1'b0, i_w1});
            r3_sq[i] <= n_diff[i] * n_diff[i];
        end
        r1_base   <= i_cls.base;
        r1_pt     <= i_cls.p;
        r1_region <= i_cls.region;
        r2_pt     <= r1_pt;
        r2_q      <= n_q;
        r2_region <= r1_region;
        r3_q      <= r2_q;
        r3_region <= r2_region;
        r4_out.sqr_distance <= DIST_BITS'(r3_sq[0]) + DIST_BITS'(r3_sq[1])
                             + DIST_BITS'(r3_sq[2]);
        r4_out.nearest_x    <= r3_q[0];
        r4_out.nearest_y    <= r3_q[1];
        r4_out.nearest_z    <= r3_q[2];
        r4_out.region       <= r3_region;
    end

    assign o_valid  = r4_valid;
    assign o_result = r4_out;

endmodule

// ===== rtl/core/point_triangle_sqr_distance_top.sv =====
// Top level of the point-triangle squared distance pipeline
//
// Usage: drive one query point and three triangle vertices on i_item and
// raise start. The transaction is taken at each rising edge where start is
// high and busy is low. A new transaction may be started in every cycle.
// Each result shows on o_result for exactly one cycle with o_strobe high;
// it is taken at the edge that ends that cycle. The receiver cannot hold
// results off and none is needed: the pipeline never stalls.
// Pipeline: each transaction passes the six 52x52 split multipliers
// (2 stages), the 25-stage weight dividers (an entry register plus 24
// quotient stages), and ten further arithmetic stages. Throughput is
// one transaction per cycle.
// Results leave in the order transactions came in.
// Reset (synchronous, active low) drops all in-flight transactions and
// holds busy high while asserted; busy is low in every cycle after.
module point_triangle_sqr_distance_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ptsd_pkg::t_in    i_item,
    output logic             o_strobe,
    output ptsd_pkg::t_out   o_result
);
    import ptsd_pkg::*;

    localparam int GEOM_LAT = 6;
    localparam int BACK_LAT = 4;
    localparam int LATENCY  = GEOM_LAT + 2 + DIV_LAT + BACK_LAT;

    logic      r_busy;
    logic      g_valid;
    t_geom_res g_res;

    logic   r7_valid;
    t_geo   r7_geo;
    t_dots  r7_d;
    t_cross r7_vb, r7_vc, r7_den;
    logic   r7_va_lez, r7_vb_lez, r7_vc_lez;

    t_dot   d1, d2, d3, d4, d5, d6;
    t_cls   n_cls;
    t_cross n_num0, n_num1, n_den0, n_den1;
    logic   n_den_lez;

    logic   r8_valid;
    t_cls   r8_cls;
    t_cross r8_num0, r8_num1, r8_den0, r8_den1;

    t_cls              r_cls_dly [DIV_LAT];
    logic [DIV_LAT-1:0] r_vld_dly;
    t_weight           w0, w1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    ptsd_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !r_busy),
        .i_item  (i_item),
        .o_valid (g_valid),
        .o_res   (g_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r_vld_dly <= '0;
        end else begin
            r7_valid  <= g_valid;
            r8_valid  <= r7_valid;
            r_vld_dly <= {r_vld_dly[DIV_LAT-2:0], r8_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r7_geo    <= g_res.geo;
        r7_d      <= g_res.d;
        r7_vb     <= g_res.vb;
        r7_vc     <= g_res.vc;
        r7_den    <= g_res.va + g_res.vb + g_res.vc;
        r7_va_lez <= g_res.va <= 0;
        r7_vb_lez <= g_res.vb <= 0;
        r7_vc_lez <= g_res.vc <= 0;
    end

    assign d1 = r7_d[0];
    assign d2 = r7_d[1];
    assign d3 = r7_d[2];
    assign d4 = r7_d[3];
    assign d5 = r7_d[4];
    assign d6 = r7_d[5];
    assign n_den_lez = r7_den <= 0;

    // Region tests in order; a zero numerator makes the divider return 0,
    // which leaves the base point untouched for vertex regions.
    always_comb begin
        n_cls.p      = r7_geo.p;
        n_cls.base   = r7_geo.a;
        n_cls.e0     = '0;
        n_cls.e1     = '0;
        n_cls.region = REG_A;
        n_num0       = '0;
        n_num1       = '0;
        n_den0       = '0;
        n_den1       = '0;
        priority if (d1 <= 0 && d2 <= 0) begin
            n_cls.region = REG_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            n_cls.region = REG_B;
            n_cls.base   = r7_geo.b;
        end else if (r7_vc_lez && d1 >= 0 && d3 <= 0) begin
            n_cls.region = REG_AB;
            n_cls.e0     = r7_geo.ab;
            n_num0       = CROSS_BITS'(d1);
            n_den0       = CROSS_BITS'(d1) - CROSS_BITS'(d3);
        end else if (d6 >= 0 && d5 <= d6) begin
            n_cls.region = REG_C;
            n_cls.base   = r7_geo.c;
        end else if (r7_vb_lez && d2 >= 0 && d6 <= 0) begin
            n_cls.region = REG_AC;
            n_cls.e0     = r7_geo.ac;
            n_num0       = CROSS_BITS'(d2);
            n_den0       = CROSS_BITS'(d2) - CROSS_BITS'(d6);
        end else if (r7_va_lez && d4 >= d3 && d5 >= d6) begin
            n_cls.region = REG_BC;
            n_cls.base   = r7_geo.b;
            n_cls.e0     = r7_geo.bc;
            n_num0       = CROSS_BITS'(d4) - CROSS_BITS'(d3);
            n_den0       = n_num0 + CROSS_BITS'(d5) - CROSS_BITS'(d6);
        end else if (n_den_lez) begin
            n_cls.region = REG_A;   // degenerate triangle
        end else begin
            n_cls.region = REG_FACE;
            n_cls.e0     = r7_geo.ab;
            n_cls.e1     = r7_geo.ac;
            n_num0       = r7_vb;
            n_num1       = r7_vc;
            n_den0       = r7_den;
            n_den1       = r7_den;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_cls  <= n_cls;
        r8_num0 <= n_num0;
        r8_num1 <= n_num1;
        r8_den0 <= n_den0;
        r8_den1 <= n_den1;
        r_cls_dly[0] <= r8_cls;
        for (int s = 1; s < DIV_LAT; s++) begin
            r_cls_dly[s] <= r_cls_dly[s-1];
        end
    end

    ptsd_div u_div0 (
        .i_clk    (i_clk),
        .i_num    (r8_num0),
        .i_den    (r8_den0),
        .o_weight (w0)
    );

    ptsd_div u_div1 (
        .i_clk    (i_clk),
        .i_num    (r8_num1),
        .i_den    (r8_den1),
        .o_weight (w1)
    );

    ptsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld_dly[DIV_LAT-1]),
        .i_cls    (r_cls_dly[DIV_LAT-1]),
        .i_w0     (w0),
        .i_w1     (w1),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result strobe missing after accepted transaction");

    a_vertex_wt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_dly[DIV_LAT-1] && (r_cls_dly[DIV_LAT-1].region == REG_A ||
         r_cls_dly[DIV_LAT-1].region == REG_B ||
         r_cls_dly[DIV_LAT-1].region == REG_C)) |-> (w0 == '0 && w1 == '0))
        else $error("nonzero weight for a vertex region");

    a_edge_wt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_dly[DIV_LAT-1] && (r_cls_dly[DIV_LAT-1].region == REG_AB ||
         r_cls_dly[DIV_LAT-1].region == REG_AC ||
         r_cls_dly[DIV_LAT-1].region == REG_BC)) |-> w1 == '0)
        else $error("second weight set for an edge region");

    a_wt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_dly[DIV_LAT-1] |-> (w0 <= WT_ONE && w1 <= WT_ONE))
        else $error("weight above one");

    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.region <= REGION_BITS'(REG_FACE))
        else $error("region code out of range");

endmodule
